// ----- design/rgbcrs_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbcrs_pkg
// Shared codes, state type and target color table of the color ramp sequencer.
// ----------------------------------------------------------------------------
package rgbcrs_pkg;

  // command codes
  localparam logic [3:0] CMD_TICK     = 4'd0;
  localparam logic [3:0] CMD_RED      = 4'd1;
  localparam logic [3:0] CMD_ORANGE   = 4'd2;
  localparam logic [3:0] CMD_BLUE     = 4'd3;
  localparam logic [3:0] CMD_FADE     = 4'd4;
  localparam logic [3:0] CMD_COOLING  = 4'd5;
  localparam logic [3:0] CMD_SHUTDOWN = 4'd6;
  localparam logic [3:0] CMD_SET      = 4'd7;
  localparam logic [3:0] CMD_CLEAR    = 4'd8;

  // ramp phases
  localparam logic [2:0] PH_HOLD   = 3'd0;
  localparam logic [2:0] PH_RED    = 3'd1;
  localparam logic [2:0] PH_ORANGE = 3'd2;
  localparam logic [2:0] PH_BLUE   = 3'd3;
  localparam logic [2:0] PH_FADE   = 3'd4;

  // sequence kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_COOL = 2'd1;
  localparam logic [1:0] KIND_SHUT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_RED_MS    = 3'd0;
  localparam logic [2:0] REG_ORANGE_MS = 3'd1;
  localparam logic [2:0] REG_BLUE_MS   = 3'd2;
  localparam logic [2:0] REG_FADE_MS   = 3'd3;
  localparam logic [2:0] REG_STEP      = 3'd4;

  localparam logic [14:0] RAMP_MS_RST = 15'd1000;
  localparam logic [7:0]  STEP_RST    = 8'd5;
  localparam logic [7:0]  LVL_FULL    = 8'd255;
  localparam logic [7:0]  LVL_LOW     = 8'd50;
  localparam logic [7:0]  LVL_OFF     = 8'd0;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [3:0] DIV_LAST = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_OUT
  } seq_state_t;

  // target level of a channel in a phase
  function automatic logic [7:0] target_level(input logic [2:0] p, input logic [1:0] c);
    logic [7:0] t;
    t = LVL_OFF;
    unique case (p)
      PH_RED:    t = (c == CH_RED) ? LVL_FULL : LVL_OFF;
      PH_ORANGE: t = (c == CH_RED) ? LVL_FULL : ((c == CH_GREEN) ? LVL_LOW : LVL_OFF);
      PH_BLUE:   t = (c == CH_BLUE) ? LVL_FULL : LVL_LOW;
      default:   t = LVL_OFF;
    endcase
    return t;
  endfunction

endpackage

// ----- design/rgb_color_ramp_sequencer.sv -----
// ----------------------------------------------------------------------------
// rgb_color_ramp_sequencer
// Ramps a three-channel color toward preset targets on millisecond ticks,
// with cooling and shutdown sequences; one shared divider and step unit.
//
// channel  ports      word fields (low bit up)
// in       in_t*      tuser: cmd[3:0]; tdata: set_red, set_green, set_blue
// out      out_t*     tdata: out_red, out_green, out_blue, phase, ramp_done
// cfg      cfg_*      cfg_index selects register, cfg_data carries value
//
// after acceptance a phase start, or a tick that opens a pending sequence
// phase, runs the restoring divider (ramp time over channel distance) per
// channel, then channel stepping, then the output state; a plain tick skips
// the divider; set color, clear and hold ticks go straight to the output state
// in_tready is low from acceptance until the result enters the output register
// the output register waits while out_tready is low; the next word is taken
// meanwhile. reset is synchronous, active low; cfg is always ready
// ----------------------------------------------------------------------------
module rgb_color_ramp_sequencer
  import rgbcrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // set_red, set_green, set_blue
  input  logic [3:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_red, out_green, out_blue, phase, ramp_done, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  seq_state_t state_r, state_nxt;

  logic [14:0] red_ms_r, orange_ms_r, blue_ms_r, fade_ms_r;
  logic [7:0]  step_r;
  logic [31:0] now_r, start_ms_r;
  logic [7:0]  level_r     [3];
  logic [7:0]  start_lvl_r [3];
  logic [15:0] intv_r      [3];
  logic [31:0] last_r      [3];
  logic [1:0]  kind_r;
  logic [2:0]  phase_r;
  logic        pending_r;
  logic [1:0]  ch_r;
  logic [3:0]  cnt_r;
  logic [7:0]  rem_r, dist_r;
  logic [14:0] quo_r;
  logic        all_at_r, done_r;
  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;

  logic [3:0]  cmd;
  logic        cmd_start, tick_run;
  logic [14:0] rt;
  logic [7:0]  tg, lv, span;
  logic [8:0]  trial;
  logic        ge;
  logic [14:0] quo_nxt;
  logic [7:0]  lv0, lv1;
  logic        fire, all_now, done_now;
  logic [31:0] since_last, elapsed;

  function automatic logic [7:0] move_level(input logic [7:0] l, input logic [7:0] from,
                                            input logic [7:0] t, input logic [7:0] inc);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, l} + {1'b0, inc};
    if (t >= from) begin
      r = (sum <= {1'b0, t}) ? sum[7:0] : t;
    end else if (inc >= l || (l - inc) < t) begin
      r = t;
    end else begin
      r = l - inc;
    end
    return r;
  endfunction

  assign cmd       = in_tuser;
  assign cmd_start = (cmd == CMD_RED) || (cmd == CMD_ORANGE) || (cmd == CMD_BLUE) ||
                     (cmd == CMD_FADE) || (cmd == CMD_COOLING) || (cmd == CMD_SHUTDOWN);
  assign tick_run  = (cmd == CMD_TICK) && (phase_r != PH_HOLD);

  always_comb begin
    unique case (phase_r)
      PH_RED:    rt = red_ms_r;
      PH_ORANGE: rt = orange_ms_r;
      PH_BLUE:   rt = blue_ms_r;
      default:   rt = fade_ms_r;
    endcase
  end

  // shared divider and channel step unit
  assign tg      = target_level(phase_r, ch_r);
  assign lv      = level_r[ch_r];
  assign span    = (tg > lv) ? (tg - lv) : (lv - tg);
  assign trial   = {rem_r, quo_r[14]};
  assign ge      = trial >= {1'b0, dist_r};
  assign quo_nxt = {quo_r[13:0], ge};

  assign lv0        = (rt == 15'd0) ? tg : lv;
  assign since_last = now_r - last_r[ch_r];
  assign fire       = (lv0 != tg) && (since_last >= {16'd0, intv_r[ch_r]});
  assign lv1        = fire ? move_level(lv0, start_lvl_r[ch_r], tg, step_r) : lv0;
  assign all_now    = all_at_r && (lv1 == tg);
  assign elapsed    = now_r - start_ms_r;
  assign done_now   = all_now || (elapsed > {17'd0, rt});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (cmd_start || (tick_run && pending_r)) begin
            state_nxt = ST_DIV;
          end else if (tick_run) begin
            state_nxt = ST_STEP;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST && ch_r == CH_BLUE) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (ch_r == CH_BLUE) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    cfg_ready  = 1'b1;
    out_tvalid = out_tvalid_r;
    out_tdata  = out_tdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_ms_r     <= RAMP_MS_RST;
      orange_ms_r  <= RAMP_MS_RST;
      blue_ms_r    <= RAMP_MS_RST;
      fade_ms_r    <= RAMP_MS_RST;
      step_r       <= STEP_RST;
      now_r        <= '0;
      start_ms_r   <= '0;
      kind_r       <= KIND_NONE;
      phase_r      <= PH_HOLD;
      pending_r    <= 1'b0;
      ch_r         <= CH_RED;
      cnt_r        <= '0;
      all_at_r     <= 1'b1;
      done_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        level_r[i]     <= '0;
        start_lvl_r[i] <= '0;
        intv_r[i]      <= '0;
        last_r[i]      <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_RED_MS:    red_ms_r    <= cfg_data;
          REG_ORANGE_MS: orange_ms_r <= cfg_data;
          REG_BLUE_MS:   blue_ms_r   <= cfg_data;
          REG_FADE_MS:   fade_ms_r   <= cfg_data;
          REG_STEP:      step_r      <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            done_r   <= 1'b0;
            ch_r     <= CH_RED;
            cnt_r    <= '0;
            all_at_r <= 1'b1;
            unique case (cmd)
              CMD_TICK: begin
                now_r <= now_r + 32'd1;
                if (phase_r != PH_HOLD) begin
                  pending_r <= 1'b0;
                end
              end
              CMD_RED, CMD_ORANGE, CMD_BLUE, CMD_FADE: begin
                kind_r    <= KIND_NONE;
                phase_r   <= cmd[2:0];
                pending_r <= 1'b0;
              end
              CMD_COOLING: begin
                kind_r    <= KIND_COOL;
                phase_r   <= PH_BLUE;
                pending_r <= 1'b0;
              end
              CMD_SHUTDOWN: begin
                kind_r    <= KIND_SHUT;
                phase_r   <= PH_RED;
                pending_r <= 1'b0;
              end
              CMD_SET: begin
                level_r[0] <= in_tdata[7:0];
                level_r[1] <= in_tdata[15:8];
                level_r[2] <= in_tdata[23:16];
              end
              CMD_CLEAR: begin
                for (int i = 0; i < 3; i++) begin
                  level_r[i] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (cnt_r == '0) begin
            start_ms_r        <= now_r;
            start_lvl_r[ch_r] <= lv;
            dist_r            <= span;
            rem_r             <= '0;
            quo_r             <= rt;
            cnt_r             <= cnt_r + 4'd1;
          end else begin
            rem_r <= ge ? 8'(trial - {1'b0, dist_r}) : trial[7:0];
            quo_r <= quo_nxt;
            if (cnt_r == DIV_LAST) begin
              intv_r[ch_r] <= (dist_r == '0) ? 16'd0 : {1'b0, quo_nxt};
              cnt_r        <= '0;
              ch_r         <= (ch_r == CH_BLUE) ? CH_RED : ch_r + 2'd1;
            end else begin
              cnt_r <= cnt_r + 4'd1;
            end
          end
        end
        ST_STEP: begin
          level_r[ch_r] <= lv1;
          if (fire) begin
            last_r[ch_r] <= now_r;
          end
          all_at_r <= all_now;
          if (ch_r == CH_BLUE) begin
            ch_r   <= CH_RED;
            done_r <= done_now;
            if (done_now) begin
              if ((kind_r == KIND_COOL || kind_r == KIND_SHUT) && phase_r == PH_BLUE) begin
                phase_r   <= PH_FADE;
                pending_r <= 1'b1;
              end else if (kind_r == KIND_SHUT && phase_r == PH_RED) begin
                phase_r   <= PH_BLUE;
                pending_r <= 1'b1;
              end else begin
                phase_r   <= PH_HOLD;
                kind_r    <= KIND_NONE;
                pending_r <= 1'b0;
              end
            end
          end else begin
            ch_r <= ch_r + 2'd1;
          end
        end
        ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {4'd0, done_r, phase_r, level_r[2], level_r[1], level_r[0]};
            out_tvalid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_hold_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HOLD) |-> !pending_r)
    else $error("pending start without an active phase");

  a_kind_needs_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r != KIND_NONE) |-> (phase_r != PH_HOLD))
    else $error("sequence kind set while holding");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready while an item is in work");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[27]) |-> (out_tdata[26:24] != PH_RED && out_tdata[26:24] != PH_ORANGE))
    else $error("completed ramp left an invalid phase");

endmodule

// ----- sim/tb_rgb_color_ramp_sequencer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_color_ramp_sequencer
// Drives commands and millisecond ticks into the color ramp sequencer through
// its input stream and compares every output word with a cycle-free model of
// the ramp and sequence behavior kept in this bench. Directed tests cover
// level writes, instant ramps, time-limited ramps and both sequences; random
// rounds then run start-and-tick bursts under several register settings,
// with random idle cycles on the input side and random stalls on the output, except in one quiet round.
// ----------------------------------------------------------------------------
module tb_rgb_color_ramp_sequencer;
  import rgbcrs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] phase;
    logic       done;
  } led_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // set_red, set_green, set_blue
  logic [3:0]  in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // out_red, out_green, out_blue, phase, ramp_done, zero pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [14:0] cfg_data;

  rgb_color_ramp_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // model state
  logic [14:0] ramp_cfg [4];
  logic [7:0]  step_amt;
  logic [31:0] clock_ms;
  logic [31:0] ph_start_ms;
  logic [7:0]  lvl [3];
  logic [7:0]  from_lvl [3];
  logic [15:0] gap_ms [3];
  logic [31:0] stepped_ms [3];
  logic [1:0]  seq_kind;
  logic [2:0]  seq_phase;
  bit          init_due;

  led_word_t expected_words [$];
  int        err_count;
  int        cycle_count;
  bit        quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_rgb_color_ramp_sequencer: errors");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= quiet || ($urandom_range(99) >= 12);

  function automatic logic [7:0] goal_level(input logic [2:0] p, input int c);
    case (p)
      PH_RED:    return (c == 0) ? LVL_FULL : LVL_OFF;
      PH_ORANGE: return (c == 0) ? LVL_FULL : ((c == 1) ? LVL_LOW : LVL_OFF);
      PH_BLUE:   return (c == 2) ? LVL_FULL : LVL_LOW;
      default:   return LVL_OFF;
    endcase
  endfunction

  // one step of the active phase, returns completion
  function automatic bit run_phase(input bit start);
    logic [2:0]  p;
    int unsigned rt;
    int unsigned tg;
    int unsigned d;
    int unsigned cur;
    bit          all_at;
    int          c;
    p = (seq_phase > PH_FADE) ? PH_FADE : seq_phase;
    case (p)
      PH_RED:    rt = ramp_cfg[REG_RED_MS];
      PH_ORANGE: rt = ramp_cfg[REG_ORANGE_MS];
      PH_BLUE:   rt = ramp_cfg[REG_BLUE_MS];
      default:   rt = ramp_cfg[REG_FADE_MS];
    endcase
    all_at = 1'b1;
    if (start) begin
      ph_start_ms = clock_ms;
      for (c = 0; c < 3; c++) begin
        tg = goal_level(p, c);
        d = (tg > lvl[c]) ? tg - lvl[c] : lvl[c] - tg;
        from_lvl[c] = lvl[c];
        gap_ms[c] = (d != 0) ? 16'(rt / d) : 16'd0;
      end
    end
    for (c = 0; c < 3; c++) begin
      tg = goal_level(p, c);
      if (rt == 0) lvl[c] = 8'(tg);
      if (lvl[c] != tg && (clock_ms - stepped_ms[c]) >= gap_ms[c]) begin
        stepped_ms[c] = clock_ms;
        cur = lvl[c];
        if (tg >= from_lvl[c]) begin
          cur = (cur + step_amt <= tg) ? cur + step_amt : tg;
        end else if (step_amt >= cur || cur - step_amt < tg) begin
          cur = tg;
        end else begin
          cur = cur - step_amt;
        end
        lvl[c] = 8'(cur);
      end
      if (lvl[c] != tg) all_at = 1'b0;
    end
    return all_at || ((clock_ms - ph_start_ms) > rt);
  endfunction

  function automatic void predict_word(input logic [3:0] cmd, input logic [23:0] data);
    bit        done;
    bit        init;
    led_word_t w;
    done = 1'b0;
    case (cmd)
      CMD_TICK: begin
        clock_ms++;
        if (seq_phase != PH_HOLD) begin
          init = init_due;
          init_due = 1'b0;
          done = run_phase(init);
        end
      end
      CMD_RED, CMD_ORANGE, CMD_BLUE, CMD_FADE: begin
        seq_kind = KIND_NONE;
        seq_phase = cmd[2:0];
        init_due = 1'b0;
        done = run_phase(1'b1);
      end
      CMD_COOLING: begin
        seq_kind = KIND_COOL;
        seq_phase = PH_BLUE;
        init_due = 1'b0;
        done = run_phase(1'b1);
      end
      CMD_SHUTDOWN: begin
        seq_kind = KIND_SHUT;
        seq_phase = PH_RED;
        init_due = 1'b0;
        done = run_phase(1'b1);
      end
      CMD_SET: begin
        lvl[0] = data[7:0];
        lvl[1] = data[15:8];
        lvl[2] = data[23:16];
      end
      CMD_CLEAR: begin
        lvl[0] = LVL_OFF;
        lvl[1] = LVL_OFF;
        lvl[2] = LVL_OFF;
      end
      default: ;
    endcase
    if (done) begin
      if ((seq_kind == KIND_COOL || seq_kind == KIND_SHUT) && seq_phase == PH_BLUE) begin
        seq_phase = PH_FADE;
        init_due = 1'b1;
      end else if (seq_kind == KIND_SHUT && seq_phase == PH_RED) begin
        seq_phase = PH_BLUE;
        init_due = 1'b1;
      end else begin
        seq_phase = PH_HOLD;
        seq_kind = KIND_NONE;
        init_due = 1'b0;
      end
    end
    w.red = lvl[0];
    w.green = lvl[1];
    w.blue = lvl[2];
    w.phase = seq_phase;
    w.done = done;
    expected_words.push_back(w);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : check_words
    led_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_tdata);
        err_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("red", want.red, out_tdata[7:0]);
        check_field("green", want.green, out_tdata[15:8]);
        check_field("blue", want.blue, out_tdata[23:16]);
        check_field("phase", {5'd0, want.phase}, {5'd0, out_tdata[26:24]});
        check_field("ramp_done", {7'd0, want.done}, {7'd0, out_tdata[27]});
      end
    end
  end

  function automatic logic [7:0] rand_level();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic [23:0] rand_color();
    return {rand_level(), rand_level(), rand_level()};
  endfunction

  task automatic send_word(input logic [3:0] cmd, input logic [23:0] data);
    while (!quiet && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(cmd, data);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_STEP) step_amt = val[7:0];
    else ramp_cfg[idx] = val;
  endtask

  task automatic load_config(input logic [14:0] red_ms, input logic [14:0] orange_ms,
                             input logic [14:0] blue_ms, input logic [14:0] fade_ms,
                             input logic [7:0] step);
    write_reg(REG_RED_MS, red_ms);
    write_reg(REG_ORANGE_MS, orange_ms);
    write_reg(REG_BLUE_MS, blue_ms);
    write_reg(REG_FADE_MS, fade_ms);
    write_reg(REG_STEP, {7'd0, step});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [14:0] rand_ramp(input bit wide);
    if (wide && $urandom_range(1) == 1) return 15'($urandom);
    return 15'($urandom_range(0, 40));
  endfunction

  task automatic test_levels();
    send_word(CMD_TICK, 24'h000000);
    send_word(CMD_SET, 24'hFFFFFF);
    send_word(CMD_SET, 24'h000000);
    send_word(CMD_SET, 24'h3CA55A);
    send_word(CMD_CLEAR, 24'hFFFFFF);
  endtask

  // zero ramp time jumps straight to the target
  task automatic test_instant_ramps();
    wait_drained();
    load_config(15'd0, 15'd0, 15'd0, 15'd0, 8'd255);
    send_word(CMD_RED, 24'h000000);
    send_word(CMD_ORANGE, 24'h000000);
    send_word(CMD_BLUE, 24'h000000);
    send_word(CMD_FADE, 24'h000000);
    send_word(CMD_TICK, 24'h000000);
  endtask

  // small step, ramp ends when elapsed time passes the ramp time
  task automatic test_time_limit();
    wait_drained();
    load_config(15'd2, 15'd2, 15'd2, 15'd2, 8'd1);
    send_word(CMD_RED, 24'h000000);
    send_word(CMD_TICK, 24'h000000);
    send_word(CMD_SET, 24'h102080);
    send_word(CMD_TICK, 24'h000000);
    send_word(CMD_TICK, 24'h000000);
  endtask

  // cooling and shutdown with a one-tick gap before each next phase
  task automatic test_sequences();
    wait_drained();
    load_config(15'd0, 15'd0, 15'd0, 15'd0, 8'd255);
    send_word(CMD_COOLING, 24'h000000);
    send_word(CMD_TICK, 24'h000000);
    send_word(CMD_SHUTDOWN, 24'h000000);
    send_word(CMD_TICK, 24'h000000);
    send_word(CMD_TICK, 24'h000000);
    send_word(CMD_TICK, 24'h000000);
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int burst;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_word(4'($urandom_range(CMD_RED, CMD_SHUTDOWN)), 24'($urandom));
        sent++;
        burst = $urandom_range(1, 60);
        repeat (burst) begin
          pick = $urandom_range(99);
          if (pick < 5) send_word(CMD_SET, rand_color());
          else if (pick < 8) send_word(CMD_CLEAR, 24'($urandom));
          else send_word(CMD_TICK, 24'($urandom));
          sent++;
        end
      end else begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          send_word(4'($urandom_range(CMD_TICK, CMD_CLEAR)), rand_color());
          sent++;
        end
      end
    end
  endtask

  initial begin
    int round;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 24'd0;
    in_tuser <= CMD_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= REG_RED_MS;
    cfg_data <= 15'd0;
    quiet = 1'b0;
    err_count = 0;
    cycle_count = 0;
    for (int i = 0; i < 4; i++) ramp_cfg[i] = RAMP_MS_RST;
    step_amt = STEP_RST;
    clock_ms = 32'd0;
    ph_start_ms = 32'd0;
    for (int i = 0; i < 3; i++) begin
      lvl[i] = 8'd0;
      from_lvl[i] = 8'd0;
      gap_ms[i] = 16'd0;
      stepped_ms[i] = 32'd0;
    end
    seq_kind = KIND_NONE;
    seq_phase = PH_HOLD;
    init_due = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_levels();
    test_instant_ramps();
    test_time_limit();
    test_sequences();

    for (round = 0; round < 6; round++) begin
      wait_drained();
      case (round)
        0: load_config(rand_ramp(0), rand_ramp(0), rand_ramp(0), rand_ramp(0),
                       8'($urandom_range(1, 255)));
        1: load_config(15'd0, 15'd0, 15'd0, 15'd0, 8'd255);
        2: load_config(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 8'd1);
        3: load_config(RAMP_MS_RST, RAMP_MS_RST, RAMP_MS_RST, RAMP_MS_RST, STEP_RST);
        default: load_config(rand_ramp(1), rand_ramp(1), rand_ramp(1), rand_ramp(1),
                             8'($urandom_range(1, 255)));
      endcase
      quiet = (round == 2);
      test_random(305);
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("tb_rgb_color_ramp_sequencer: clean");
    end else begin
      $display("tb_rgb_color_ramp_sequencer: errors");
    end
    $finish;
  end

endmodule
